FILE: rtl/ppp_pkg.sv
//------------------------------------------------------------------------------
// ppp_pkg
// Widths, register indexes, control types and alphabet tables for the
// passcode character generator.
//------------------------------------------------------------------------------
`default_nettype none

package ppp_pkg;

  localparam int unsigned CipherW        = 64;
  localparam int unsigned BlockW         = 2 * CipherW;
  localparam int unsigned DigitW         = 8;
  localparam int unsigned NumSteps       = BlockW / DigitW;
  localparam int unsigned StepW          = $clog2(NumSteps);
  localparam int unsigned CharW          = 7;
  localparam int unsigned RemW           = 7;
  localparam int unsigned SelW           = 3;
  localparam int unsigned LenW           = 5;
  localparam int unsigned CfgIdxW        = 2;
  localparam int unsigned CfgDataW       = 8;
  localparam int unsigned MaxCodeLength  = 16;
  localparam int unsigned MinCodeLength  = 2;

  localparam logic [CfgIdxW-1:0] REG_ALPHABET_SELECT = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] REG_CHAR_COUNT      = CfgIdxW'(1);

  localparam logic [SelW-1:0] SEL_SIMPLE      = SelW'(1);
  localparam logic [SelW-1:0] SEL_EXTENDED    = SelW'(2);
  localparam logic [SelW-1:0] SEL_SIMPLE_NV   = SelW'(3);
  localparam logic [SelW-1:0] SEL_EXTENDED_NV = SelW'(4);
  localparam logic [SelW-1:0] SEL_ALNUM       = SelW'(5);

  localparam logic [SelW-1:0] ALPHABET_SELECT_RST = SEL_SIMPLE;
  localparam logic [LenW-1:0] CHAR_COUNT_RST      = LenW'(4);

  localparam int unsigned LenSimple     = 64;
  localparam int unsigned LenExtended   = 88;
  localparam int unsigned LenSimpleNv   = 54;
  localparam int unsigned LenExtendedNv = 77;
  localparam int unsigned LenAlnum      = 56;

  localparam logic [8*LenSimple-1:0] ABC_SIMPLE =
    "!#%+23456789:=?@ABCDEFGHJKLMNPRSTUVWXYZabcdefghijkmnopqrstuvwxyz";
  localparam logic [8*LenExtended-1:0] ABC_EXTENDED =
    "!\"#$%&'()*+,-./23456789:;<=>?@ABCDEFGHJKLMNOPRSTUVWXYZ[\\]^_abcdefghijkmnopqrstuvwxyz{|}~";
  localparam logic [8*LenSimpleNv-1:0] ABC_SIMPLE_NV =
    "!#%+23456789:=?@BCDFGHJKLMNPRSTVWXZbcdfghjkmnpqrstvwxz";
  localparam logic [8*LenExtendedNv-1:0] ABC_EXTENDED_NV =
    "!\"#$%&'()*+,-./23456789:;<=>?@BCDFGHJKLMNPRSTVWXZ[\\]^_bcdfghjkmnpqrstvwxz{|}~";
  localparam logic [8*LenAlnum-1:0] ABC_ALNUM =
    "23456789ABCDEFGHJKLMNPRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic load;
    logic step;
    logic first;
  } div_ctrl_t;

  function automatic logic [RemW-1:0] abc_len(input logic [SelW-1:0] sel);
    logic [RemW-1:0] len;
    unique case (sel)
      SEL_EXTENDED:    len = RemW'(LenExtended);
      SEL_SIMPLE_NV:   len = RemW'(LenSimpleNv);
      SEL_EXTENDED_NV: len = RemW'(LenExtendedNv);
      SEL_ALNUM:       len = RemW'(LenAlnum);
      default:         len = RemW'(LenSimple);
    endcase
    return len;
  endfunction

  // idx is always below the length of the selected alphabet
  function automatic logic [CharW-1:0] abc_char(input logic [SelW-1:0] sel,
                                                input logic [RemW-1:0] idx);
    logic [CharW-1:0] ch;
    int               i;
    i = int'(idx);
    unique case (sel)
      SEL_EXTENDED:    ch = ABC_EXTENDED[8*(LenExtended-1-i) +: CharW];
      SEL_SIMPLE_NV:   ch = ABC_SIMPLE_NV[8*(LenSimpleNv-1-i) +: CharW];
      SEL_EXTENDED_NV: ch = ABC_EXTENDED_NV[8*(LenExtendedNv-1-i) +: CharW];
      SEL_ALNUM:       ch = ABC_ALNUM[8*(LenAlnum-1-i) +: CharW];
      default:         ch = ABC_SIMPLE[8*(LenSimple-1-i) +: CharW];
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/ppp_if.sv
//------------------------------------------------------------------------------
// ppp_if
// Valid/ready channels: cipher block input, passcode character output and
// register write port.
//------------------------------------------------------------------------------
`default_nettype none

interface ppp_cipher_if;
  logic                          valid;
  logic                          ready;
  logic [ppp_pkg::CipherW-1:0]   cipher_high;
  logic [ppp_pkg::CipherW-1:0]   cipher_low;

  modport source (output valid, cipher_high, cipher_low, input ready);
  modport sink   (input valid, cipher_high, cipher_low, output ready);
endinterface

interface ppp_char_if;
  logic                          valid;
  logic                          ready;
  logic [ppp_pkg::CharW-1:0]     passcode_char;
  logic                          last_char;

  modport source (output valid, passcode_char, last_char, input ready);
  modport sink   (input valid, passcode_char, last_char, output ready);
endinterface

interface ppp_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [ppp_pkg::CfgIdxW-1:0]   index;
  logic [ppp_pkg::CfgDataW-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/ppp_div.sv
//------------------------------------------------------------------------------
// ppp_div
// Byte-serial long division of the 128-bit block by a small divisor. One
// byte per step, quotient bytes shift back in, remainder kept.
//------------------------------------------------------------------------------
`default_nettype none

module ppp_div (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire  ppp_pkg::div_ctrl_t        ctrl_i,
  input  wire  [ppp_pkg::BlockW-1:0]      block_i,
  input  wire  [ppp_pkg::RemW-1:0]        divisor_i,
  output logic [ppp_pkg::RemW-1:0]        rem_o
);

  logic [ppp_pkg::BlockW-1:0] val_q, val_d;
  logic [ppp_pkg::RemW-1:0]   rem_q, rem_d;
  logic [ppp_pkg::DigitW-1:0] quot;
  logic [ppp_pkg::RemW-1:0]   rem_in;
  logic [ppp_pkg::RemW-1:0]   rem_nx;

  // restoring divide of {rem, byte} by divisor, one bit per inner step
  always_comb begin
    logic [ppp_pkg::RemW:0]     t;
    logic [ppp_pkg::RemW-1:0]   r;
    logic [ppp_pkg::DigitW-1:0] b;
    rem_in = ctrl_i.first ? '0 : rem_q;
    r      = rem_in;
    b      = val_q[ppp_pkg::BlockW-1 -: ppp_pkg::DigitW];
    quot   = '0;
    for (int i = ppp_pkg::DigitW - 1; i >= 0; i--) begin
      t = {r, b[i]};
      if (t >= {1'b0, divisor_i}) begin
        t       = t - {1'b0, divisor_i};
        quot[i] = 1'b1;
      end
      r = t[ppp_pkg::RemW-1:0];
    end
    rem_nx = r;
  end

  always_comb begin
    val_d = val_q;
    rem_d = rem_q;
    if (ctrl_i.load) begin
      val_d = block_i;
      rem_d = '0;
    end else if (ctrl_i.step) begin
      val_d = {val_q[ppp_pkg::BlockW-ppp_pkg::DigitW-1:0], quot};
      rem_d = rem_nx;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else begin
      rem_q <= rem_d;
    end
  end

  assign rem_o = rem_q;

endmodule

`default_nettype wire

FILE: rtl/cipher_to_passcode_chars.sv
//------------------------------------------------------------------------------
// cipher_to_passcode_chars
// Turns one 128-bit encrypted counter block into passcode characters.
//------------------------------------------------------------------------------
// One block is taken while the block is idle. Each character comes from one
// division of the whole block by the alphabet length, done one byte per
// cycle by the byte-serial divider, followed by an output state in which
// the character is offered until it is taken. Characters leave least
// significant digit first; the final one carries last_char. Registers:
// index 0 alphabet_select, index 1 character count; write them only while
// idle.
//------------------------------------------------------------------------------
`default_nettype none

module cipher_to_passcode_chars #(
  parameter int unsigned MaxCodeLength = ppp_pkg::MaxCodeLength
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  ppp_cfg_if.sink      cfg_i,
  ppp_cipher_if.sink   cipher_i,
  ppp_char_if.source   char_o
);

  localparam int unsigned DigCntW = (MaxCodeLength > 1) ? $clog2(MaxCodeLength) : 1;

  ppp_pkg::state_e             state_q, state_d;
  logic [ppp_pkg::StepW-1:0]   step_q, step_d;
  logic [DigCntW-1:0]          digit_q, digit_d;
  logic [DigCntW-1:0]          nm1_q, nm1_d;
  logic [ppp_pkg::SelW-1:0]    sel_q, sel_d;
  logic [ppp_pkg::SelW-1:0]    alphabet_select_q;
  logic [ppp_pkg::LenW-1:0]    char_count_q;
  ppp_pkg::div_ctrl_t          div_ctrl;
  logic [ppp_pkg::RemW-1:0]    div_rem;
  logic [ppp_pkg::RemW-1:0]    div_len;
  logic                        last;

  // register writes
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alphabet_select_q <= ppp_pkg::ALPHABET_SELECT_RST;
      char_count_q      <= ppp_pkg::CHAR_COUNT_RST;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == ppp_pkg::REG_ALPHABET_SELECT) begin
        alphabet_select_q <= cfg_i.data[ppp_pkg::SelW-1:0];
      end else if (cfg_i.index == ppp_pkg::REG_CHAR_COUNT) begin
        char_count_q <= cfg_i.data[ppp_pkg::LenW-1:0];
      end
    end
  end

  assign div_len = ppp_pkg::abc_len(sel_q);
  assign last    = (digit_q == nm1_q);

  ppp_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (div_ctrl),
    .block_i   ({cipher_i.cipher_high, cipher_i.cipher_low}),
    .divisor_i (div_len),
    .rem_o     (div_rem)
  );

  assign char_o.passcode_char = ppp_pkg::abc_char(sel_q, div_rem);
  assign char_o.last_char     = last;

  always_comb begin
    state_d        = state_q;
    step_d         = step_q;
    digit_d        = digit_q;
    nm1_d          = nm1_q;
    sel_d          = sel_q;
    div_ctrl       = '0;
    cipher_i.ready = 1'b0;
    char_o.valid   = 1'b0;
    unique case (state_q)
      ppp_pkg::ST_IDLE: begin
        cipher_i.ready = 1'b1;
        if (cipher_i.valid) begin
          div_ctrl.load = 1'b1;
          step_d        = '0;
          digit_d       = '0;
          if (alphabet_select_q == '0 || alphabet_select_q > ppp_pkg::SEL_ALNUM) begin
            sel_d = ppp_pkg::SEL_SIMPLE;
          end else begin
            sel_d = alphabet_select_q;
          end
          if (char_count_q < ppp_pkg::LenW'(ppp_pkg::MinCodeLength)) begin
            nm1_d = DigCntW'(ppp_pkg::MinCodeLength - 1);
          end else if (char_count_q > ppp_pkg::LenW'(MaxCodeLength)) begin
            nm1_d = DigCntW'(MaxCodeLength - 1);
          end else begin
            nm1_d = DigCntW'(char_count_q - ppp_pkg::LenW'(1));
          end
          state_d = ppp_pkg::ST_DIV;
        end
      end
      ppp_pkg::ST_DIV: begin
        div_ctrl.step  = 1'b1;
        div_ctrl.first = (step_q == '0);
        step_d         = step_q + ppp_pkg::StepW'(1);
        if (step_q == ppp_pkg::StepW'(ppp_pkg::NumSteps - 1)) begin
          state_d = ppp_pkg::ST_OUT;
        end
      end
      ppp_pkg::ST_OUT: begin
        char_o.valid = 1'b1;
        if (char_o.ready) begin
          if (last) begin
            state_d = ppp_pkg::ST_IDLE;
          end else begin
            digit_d = digit_q + DigCntW'(1);
            step_d  = '0;
            state_d = ppp_pkg::ST_DIV;
          end
        end
      end
      default: begin
        state_d = ppp_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ppp_pkg::ST_IDLE;
      step_q  <= '0;
      digit_q <= '0;
      nm1_q   <= '0;
      sel_q   <= ppp_pkg::SEL_SIMPLE;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      digit_q <= digit_d;
      nm1_q   <= nm1_d;
      sel_q   <= sel_d;
    end
  end

`ifndef SYNTHESIS
  a_no_accept_while_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cipher_i.valid && cipher_i.ready) |-> !char_o.valid)
    else $error("block accepted while a character is pending");

  a_rem_below_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    char_o.valid |-> (div_rem < div_len))
    else $error("remainder not below alphabet length");

  a_last_returns_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (char_o.valid && char_o.ready && char_o.last_char) |=> cipher_i.ready)
    else $error("not idle after last character transfer");

  a_div_done_offers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ppp_pkg::ST_DIV && step_q == ppp_pkg::StepW'(ppp_pkg::NumSteps - 1))
    |=> char_o.valid)
    else $error("character not offered after final division step");
`endif

endmodule

`default_nettype wire

FILE: tb/tb.sv
//------------------------------------------------------------------------------
// tb
// Self-checking bench for cipher_to_passcode_chars: drives cipher blocks and
// register writes, predicts each passcode by 128-bit division, and checks
// every character and its last flag in order.
//------------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT   = 1500000;
  localparam int unsigned DRAIN_CYCLES  = 300;
  localparam int unsigned RAND_PHASES   = 10;
  localparam int unsigned PHASE_BLOCKS  = 50;

  // indexes past the register list; writes there must be dropped
  localparam logic [ppp_pkg::CfgIdxW-1:0] REG_SPARE_A = ppp_pkg::CfgIdxW'(2);
  localparam logic [ppp_pkg::CfgIdxW-1:0] REG_SPARE_B = ppp_pkg::CfgIdxW'(3);

  localparam logic [ppp_pkg::CipherW-1:0] ONES = {ppp_pkg::CipherW{1'b1}};

  typedef struct packed {
    logic [ppp_pkg::CipherW-1:0] high;
    logic [ppp_pkg::CipherW-1:0] low;
  } cipher_block_t;

  typedef struct packed {
    logic [ppp_pkg::CharW-1:0] ch;
    logic                      last;
  } passcode_char_t;

  logic clk_i;
  logic rst_ni;

  ppp_cfg_if    cfg_bus ();
  ppp_cipher_if blk_bus ();
  ppp_char_if   chr_bus ();

  cipher_to_passcode_chars dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_bus),
    .cipher_i (blk_bus),
    .char_o   (chr_bus)
  );

  cipher_block_t  pending_blocks [$];
  passcode_char_t expected_chars [$];

  logic [ppp_pkg::SelW-1:0] cur_sel;
  logic [ppp_pkg::LenW-1:0] cur_len;

  bit          blk_taken;
  bit          idle_on;
  int unsigned blk_gap;
  int unsigned chr_stall;
  int unsigned errors;
  int unsigned cycles;

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  task automatic report_mismatch(input string msg);
    errors++;
    $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  function automatic string alphabet_for(input logic [ppp_pkg::SelW-1:0] sel);
    string abc;
    case (sel)
      ppp_pkg::SEL_EXTENDED: begin
        abc = "!\"#$%&'()*+,-./23456789:;<=>?@ABCDEFGHJKLMNOPRSTUVWXYZ[\\]^_abcdefghijkmnopqrstuvwxyz{|}~";
      end
      ppp_pkg::SEL_SIMPLE_NV: begin
        abc = "!#%+23456789:=?@BCDFGHJKLMNPRSTVWXZbcdfghjkmnpqrstvwxz";
      end
      ppp_pkg::SEL_EXTENDED_NV: begin
        abc = "!\"#$%&'()*+,-./23456789:;<=>?@BCDFGHJKLMNPRSTVWXZ[\\]^_bcdfghjkmnpqrstvwxz{|}~";
      end
      ppp_pkg::SEL_ALNUM: begin
        abc = "23456789ABCDEFGHJKLMNPRSTUVWXYZabcdefghijkmnopqrstuvwxyz";
      end
      default: begin
        abc = "!#%+23456789:=?@ABCDEFGHJKLMNPRSTUVWXYZabcdefghijkmnopqrstuvwxyz";
      end
    endcase
    return abc;
  endfunction

  // least significant digit first, one char per division by the radix
  task automatic predict_passcode(input cipher_block_t blk);
    logic [ppp_pkg::BlockW-1:0] value;
    string                      abc;
    int unsigned                radix;
    int unsigned                digits;
    int unsigned                idx;
    byte                        code;
    passcode_char_t             exp_char;
    abc    = alphabet_for(cur_sel);
    radix  = abc.len();
    digits = cur_len;
    if (digits < ppp_pkg::MinCodeLength) digits = ppp_pkg::MinCodeLength;
    if (digits > ppp_pkg::MaxCodeLength) digits = ppp_pkg::MaxCodeLength;
    value = {blk.high, blk.low};
    for (int unsigned i = 0; i < digits; i++) begin
      idx           = int'(value % radix);
      value         = value / radix;
      code          = abc[idx];
      exp_char.ch   = code[ppp_pkg::CharW-1:0];
      exp_char.last = (i == digits - 1);
      expected_chars.push_back(exp_char);
    end
  endtask

  // sampling at the rising edge: predictions, register shadow, char checks
  always @(posedge clk_i or negedge rst_ni) begin
    passcode_char_t got;
    passcode_char_t want;
    if (!rst_ni) begin
      cur_sel   = ppp_pkg::ALPHABET_SELECT_RST;
      cur_len   = ppp_pkg::CHAR_COUNT_RST;
      blk_taken = 1'b0;
    end else begin
      blk_taken = blk_bus.valid && blk_bus.ready;
      if (blk_taken) begin
        predict_passcode('{high: blk_bus.cipher_high, low: blk_bus.cipher_low});
      end
      if (cfg_bus.valid && cfg_bus.ready) begin
        if (cfg_bus.index == ppp_pkg::REG_ALPHABET_SELECT) begin
          cur_sel = cfg_bus.data[ppp_pkg::SelW-1:0];
        end else if (cfg_bus.index == ppp_pkg::REG_CHAR_COUNT) begin
          cur_len = cfg_bus.data[ppp_pkg::LenW-1:0];
        end
      end
      if (chr_bus.valid && chr_bus.ready) begin
        got.ch   = chr_bus.passcode_char;
        got.last = chr_bus.last_char;
        if (expected_chars.size() == 0) begin
          report_mismatch($sformatf("unexpected char 0x%02h last=%0b", got.ch, got.last));
        end else begin
          want = expected_chars.pop_front();
          if (got.ch !== want.ch) begin
            report_mismatch($sformatf("passcode_char 0x%02h, expected 0x%02h",
                                      got.ch, want.ch));
          end
          if (got.last !== want.last) begin
            report_mismatch($sformatf("last_char %0b, expected %0b", got.last, want.last));
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("** cipher_to_passcode_chars: FAILED **");
      $finish;
    end
  end

  // block driver, fed from pending_blocks
  always @(negedge clk_i) begin
    cipher_block_t nxt;
    if (!rst_ni) begin
      blk_bus.valid <= 1'b0;
    end else if (blk_bus.valid && !blk_taken) begin
      // hold until the transfer happens
    end else if (blk_gap > 0) begin
      blk_gap--;
      blk_bus.valid <= 1'b0;
    end else if (pending_blocks.size() > 0) begin
      nxt = pending_blocks.pop_front();
      blk_bus.cipher_high <= nxt.high;
      blk_bus.cipher_low  <= nxt.low;
      blk_bus.valid       <= 1'b1;
      if (idle_on && $urandom_range(0, 3) == 0) blk_gap = $urandom_range(1, 13);
    end else begin
      blk_bus.valid <= 1'b0;
    end
  end

  // char sink back-pressure
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      chr_bus.ready <= 1'b0;
    end else if (chr_stall > 0) begin
      chr_stall--;
      chr_bus.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      chr_stall = $urandom_range(0, 12);
      chr_bus.ready <= 1'b0;
    end else begin
      chr_bus.ready <= 1'b1;
    end
  end

  task automatic write_reg(input logic [ppp_pkg::CfgIdxW-1:0] idx,
                           input logic [ppp_pkg::CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    cfg_bus.valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_bus.ready);
    @(negedge clk_i);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_blocks.size() != 0 || blk_bus.valid || expected_chars.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic configure(input logic [ppp_pkg::CfgDataW-1:0] sel_val,
                           input logic [ppp_pkg::CfgDataW-1:0] len_val);
    wait_idle();
    write_reg(ppp_pkg::REG_ALPHABET_SELECT, sel_val);
    write_reg(ppp_pkg::REG_CHAR_COUNT, len_val);
  endtask

  task automatic push_block(input logic [ppp_pkg::CipherW-1:0] hi,
                            input logic [ppp_pkg::CipherW-1:0] lo);
    pending_blocks.push_back('{high: hi, low: lo});
  endtask

  function automatic logic [ppp_pkg::CipherW-1:0] random_half();
    logic [ppp_pkg::CipherW-1:0] h;
    case ($urandom_range(0, 7))
      0:       h = '0;
      1:       h = ONES;
      2:       h = ppp_pkg::CipherW'($urandom_range(0, 255));
      3:       h = ppp_pkg::CipherW'(1) << $urandom_range(0, ppp_pkg::CipherW - 1);
      default: h = {$urandom, $urandom};
    endcase
    return h;
  endfunction

  initial begin
    logic [ppp_pkg::CfgDataW-1:0] sel_val;
    logic [ppp_pkg::CfgDataW-1:0] len_val;
    rst_ni              = 1'b0;
    idle_on             = 1'b1;
    blk_gap             = 0;
    chr_stall           = 0;
    errors              = 0;
    cycles              = 0;
    cfg_bus.valid       = 1'b0;
    cfg_bus.index       = '0;
    cfg_bus.data        = '0;
    blk_bus.valid       = 1'b0;
    blk_bus.cipher_high = '0;
    blk_bus.cipher_low  = '0;
    chr_bus.ready       = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings first
    push_block('0, 64'd63);
    push_block(ONES, ONES);

    configure(ppp_pkg::CfgDataW'(ppp_pkg::SEL_SIMPLE), 8'd16);
    push_block('0, '0);
    push_block(ONES, ONES);
    push_block('0, 64'd1);
    push_block(ONES, '0);
    push_block('0, ONES);

    configure(ppp_pkg::CfgDataW'(ppp_pkg::SEL_EXTENDED), 8'd16);
    push_block(ONES, ONES);
    push_block(64'h8000_0000_0000_0000, '0);
    push_block('0, 64'd87);
    push_block(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);

    configure(ppp_pkg::CfgDataW'(ppp_pkg::SEL_SIMPLE_NV), 8'd2);
    push_block('0, 64'd53);
    push_block(ONES, ONES);

    // upper data bits dropped: 0xFC selects 4, 0x3F gives 31, capped at 16
    configure(8'hFC, 8'h3F);
    push_block('0, 64'd76);
    push_block(ONES, ONES);

    // 0xE1 leaves length 1, raised to 2
    configure(ppp_pkg::CfgDataW'(ppp_pkg::SEL_ALNUM), 8'hE1);
    push_block('0, 64'd55);
    push_block(ONES, ONES);

    configure(8'h00, 8'h00);
    push_block(ONES, ONES);
    push_block(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210);

    configure(8'h07, 8'd17);
    push_block(ONES, ONES);

    // writes past the register list must not disturb selector 6 / length 3
    configure(8'h06, 8'd3);
    write_reg(REG_SPARE_A, 8'hFF);
    write_reg(REG_SPARE_B, 8'h00);
    write_reg(REG_SPARE_B, 8'h25);
    push_block(ONES, ONES);
    push_block('0, 64'd12345);

    for (int unsigned p = 0; p < RAND_PHASES; p++) begin
      if ($urandom_range(0, 4) == 0) begin
        sel_val = ppp_pkg::CfgDataW'($urandom_range(0, 255));
      end else begin
        sel_val = {(ppp_pkg::CfgDataW - ppp_pkg::SelW)'($urandom_range(0, 31)),
                   ppp_pkg::SelW'($urandom_range(1, 5))};
      end
      if ($urandom_range(0, 4) == 0) begin
        len_val = ppp_pkg::CfgDataW'($urandom_range(0, 255));
      end else begin
        len_val = ppp_pkg::CfgDataW'($urandom_range(ppp_pkg::MinCodeLength,
                                                    ppp_pkg::MaxCodeLength));
      end
      wait_idle();
      idle_on = (p != RAND_PHASES - 1) && ($urandom_range(0, 3) != 0);
      configure(sel_val, len_val);
      if ($urandom_range(0, 2) == 0) begin
        write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                  ppp_pkg::CfgDataW'($urandom_range(0, 255)));
      end
      for (int unsigned k = 0; k < PHASE_BLOCKS; k++) begin
        push_block(random_half(), random_half());
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("** cipher_to_passcode_chars: PASSED **");
    end else begin
      $display("** cipher_to_passcode_chars: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: cipher_to_passcode_chars.f
rtl/ppp_pkg.sv
rtl/ppp_if.sv
rtl/ppp_div.sv
rtl/cipher_to_passcode_chars.sv
tb/tb.sv
